// File: hw/rtl/ffsa_pkg.sv
// Package with types, constants and helpers of the first-fit segment allocator.
`default_nettype none

package ffsa_pkg;

    // Bytes of header in front of each segment's data space.
    localparam int HEADER_BYTES = 48;
    // Smallest data space worth splitting off as a new free segment.
    localparam int MIN_BLOCK_BYTES = 8;
    // Default depth of the segment table.
    localparam int MAX_SEGMENTS_DEF = 64;
    // Buffer size after reset.
    localparam logic [15:0] BUFFER_BYTES_RST = 16'd4096;

    localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
    localparam logic [17:0] HDR_MIN18 = 18'(HEADER_BYTES + MIN_BLOCK_BYTES);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [15:0] release_offset;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_offset;
        logic [15:0] granted_bytes;
    } out_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] total;
        logic        in_use;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ASHIFT,
        S_AWR_NEW,
        S_AWR_HIT,
        S_FEVAL,
        S_FWR,
        S_FSHIFT,
        S_RESP
    } state_t;

    // Data space of a segment, zero when the segment is smaller than a header.
    function automatic logic [15:0] capacity(input logic [15:0] total);
        capacity = (total >= HDR16) ? (total - HDR16) : 16'd0;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator with coalescing.
`default_nettype none

// Channel   Direction  Handshake              Beat
// s_        in         s_valid / s_ready      one request (mode, size, offset)
// m_        out        m_valid / m_ready      one result (status, offset, size)
// cfg_      in         cfg_wr_en, no wait     new buffer size
//
// One request is handled at a time. The scan reads one table entry per cycle until it finds the
// entry; a split or a merge then moves the later entries at one per cycle, and the table writes
// and the result follow. Scan and move walk the table once together.
// Reset and each buffer size write leave one free segment; entries past the count are unused.
// A result waits in the output register while the consumer stalls, and the input is open again.
module first_fit_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ffsa_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ffsa_pkg::out_t      m_data,
    input  wire logic           cfg_wr_en,
    input  wire logic [15:0]    cfg_wr_data
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    // Control state.
    ffsa_pkg::state_t state_reg, state_next;
    logic [15:0]      buf_bytes_reg;
    logic             fresh_reg;          // entry zero not yet written since init
    logic [CW-1:0]    seg_cnt_reg, seg_cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             pw_vld_reg, pw_vld_next;
    logic             m_valid_reg, m_valid_next;

    // Payload and datapath registers.
    logic             mode_reg, mode_next;
    logic [15:0]      req_reg, req_next;
    logic [15:0]      rel_reg, rel_next;
    logic [16:0]      alloc_reg, alloc_next;
    logic [17:0]      need_reg, need_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    chk_idx_reg, chk_idx_next;
    ffsa_pkg::seg_t   prev_reg, prev_next;
    ffsa_pkg::seg_t   hit_reg, hit_next;
    logic [CW-1:0]    hit_idx_reg, hit_idx_next;
    logic             split_reg, split_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [AW-1:0]    pw_addr_reg, pw_addr_next;
    logic [15:0]      mstart_reg, mstart_next;
    logic [15:0]      mtotal_reg, mtotal_next;
    logic [CW-1:0]    widx_reg, widx_next;
    logic [1:0]       rm_cnt_reg, rm_cnt_next;
    ffsa_pkg::out_t   res_reg, res_next;
    ffsa_pkg::out_t   m_data_reg, m_data_next;

    // Segment table memory, one read and one write port.
    ffsa_pkg::seg_t   seg_mem [MAX_SEGMENTS];
    ffsa_pkg::seg_t   rd_data_reg;
    logic             rd_fresh_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    ffsa_pkg::seg_t   mem_wdata;

    // Decoded conditions shared by the state machine and the datapath.
    ffsa_pkg::seg_t   rd_entry;
    logic [15:0]      ent_cap;
    logic             chk_live;
    logic             chk_end;
    logic             alloc_hit;
    logic             free_hit;
    logic             hit;
    logic             split_ok;
    logic             out_free;
    logic             ashift_more;
    logic             fshift_more;
    logic [15:0]      head16;
    logic             next_free;
    logic             prev_free;
    logic [15:0]      sum_hn;
    logic [16:0]      alloc_rnd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= seg_mem[mem_raddr];
    end

    // Until entry zero is written after init, it reads as the whole buffer, free.
    always_comb begin
        if (rd_fresh_reg) begin
            rd_entry.start  = 16'd0;
            rd_entry.total  = buf_bytes_reg;
            rd_entry.in_use = 1'b0;
        end else begin
            rd_entry = rd_data_reg;
        end
    end

    assign ent_cap     = ffsa_pkg::capacity(rd_entry.total);
    assign chk_live    = chk_vld_reg && (chk_idx_reg < seg_cnt_reg);
    assign chk_end     = chk_vld_reg && !(chk_idx_reg < seg_cnt_reg);
    assign alloc_hit   = !rd_entry.in_use && (ent_cap >= req_reg);
    assign free_hit    = ((rd_entry.start + ffsa_pkg::HDR16) == rel_reg);
    assign hit         = chk_live && ((mode_reg == ffsa_pkg::MODE_FREE) ? free_hit : alloc_hit);
    assign split_ok    = (need_reg <= {2'b00, ent_cap}) && (seg_cnt_reg < MAX_CNT);
    assign out_free    = !m_valid_reg || m_ready;
    assign ashift_more = (k_reg > hit_idx_reg);
    assign fshift_more = (k_reg < seg_cnt_reg);
    assign head16      = ffsa_pkg::HDR16 + alloc_reg[15:0];
    assign next_free   = (({1'b0, hit_idx_reg} + 1'b1) < {1'b0, seg_cnt_reg})
                         && !rd_entry.in_use;
    assign prev_free   = (hit_idx_reg != '0) && !prev_reg.in_use;
    assign sum_hn      = hit_reg.total + (next_free ? rd_entry.total : 16'd0);
    assign alloc_rnd   = ({1'b0, s_data.request_bytes} + 17'd7) & ~17'h7;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffsa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = ffsa_pkg::S_SCAN;
                end
            end
            ffsa_pkg::S_SCAN: begin
                if (chk_end) begin
                    state_next = ffsa_pkg::S_RESP;
                end else if (hit) begin
                    if (mode_reg == ffsa_pkg::MODE_FREE) begin
                        state_next = rd_entry.in_use ? ffsa_pkg::S_FEVAL : ffsa_pkg::S_RESP;
                    end else begin
                        state_next = split_ok ? ffsa_pkg::S_ASHIFT : ffsa_pkg::S_AWR_HIT;
                    end
                end
            end
            ffsa_pkg::S_ASHIFT: begin
                if (!ashift_more) begin
                    state_next = ffsa_pkg::S_AWR_NEW;
                end
            end
            ffsa_pkg::S_AWR_NEW: state_next = ffsa_pkg::S_AWR_HIT;
            ffsa_pkg::S_AWR_HIT: state_next = ffsa_pkg::S_RESP;
            ffsa_pkg::S_FEVAL:   state_next = ffsa_pkg::S_FWR;
            ffsa_pkg::S_FWR: begin
                state_next = (rm_cnt_reg == 2'd0) ? ffsa_pkg::S_RESP : ffsa_pkg::S_FSHIFT;
            end
            ffsa_pkg::S_FSHIFT: begin
                if (!fshift_more) begin
                    state_next = ffsa_pkg::S_RESP;
                end
            end
            ffsa_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = ffsa_pkg::S_IDLE;
                end
            end
            default: state_next = ffsa_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = rd_entry;
        mem_raddr     = '0;
        seg_cnt_next  = seg_cnt_reg;
        chk_vld_next  = 1'b0;
        pw_vld_next   = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mode_next     = mode_reg;
        req_next      = req_reg;
        rel_next      = rel_reg;
        alloc_next    = alloc_reg;
        need_next     = need_reg;
        idx_next      = idx_reg;
        chk_idx_next  = chk_idx_reg;
        prev_next     = prev_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        split_next    = split_reg;
        k_next        = k_reg;
        pw_addr_next  = pw_addr_reg;
        mstart_next   = mstart_reg;
        mtotal_next   = mtotal_reg;
        widx_next     = widx_reg;
        rm_cnt_next   = rm_cnt_reg;
        res_next      = res_reg;
        case (state_reg)
            ffsa_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                mode_next  = s_data.mode;
                req_next   = s_data.request_bytes;
                rel_next   = s_data.release_offset;
                alloc_next = alloc_rnd;
                need_next  = {1'b0, alloc_rnd} + ffsa_pkg::HDR_MIN18;
                idx_next   = '0;
            end
            ffsa_pkg::S_SCAN: begin
                // Read one entry ahead while checking the one read last cycle.
                mem_raddr    = idx_reg[AW-1:0];
                idx_next     = idx_reg + 1'b1;
                chk_idx_next = idx_reg;
                chk_vld_next = 1'b1;
                if (chk_vld_reg) begin
                    prev_next = rd_entry;
                end
                if (chk_end) begin
                    res_next.status = (mode_reg == ffsa_pkg::MODE_FREE) ?
                                      ffsa_pkg::ST_BAD_FREE : ffsa_pkg::ST_NO_SPACE;
                    res_next.data_offset   = 16'd0;
                    res_next.granted_bytes = 16'd0;
                end else if (hit) begin
                    hit_next     = rd_entry;
                    hit_idx_next = chk_idx_reg;
                    split_next   = split_ok;
                    k_next       = seg_cnt_reg - 1'b1;
                    prev_next    = prev_reg;
                    if (mode_reg == ffsa_pkg::MODE_FREE && !rd_entry.in_use) begin
                        res_next.status        = ffsa_pkg::ST_BAD_FREE;
                        res_next.data_offset   = 16'd0;
                        res_next.granted_bytes = 16'd0;
                    end
                end
            end
            ffsa_pkg::S_ASHIFT: begin
                // Move entries above the hit up by one, top first.
                if (pw_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pw_addr_reg;
                    mem_wdata = rd_entry;
                end
                if (ashift_more) begin
                    mem_raddr    = k_reg[AW-1:0];
                    pw_vld_next  = 1'b1;
                    pw_addr_next = AW'(k_reg + 1'b1);
                    k_next       = k_reg - 1'b1;
                end
            end
            ffsa_pkg::S_AWR_NEW: begin
                mem_we           = 1'b1;
                mem_waddr        = AW'(hit_idx_reg + 1'b1);
                mem_wdata.start  = hit_reg.start + head16;
                mem_wdata.total  = hit_reg.total - head16;
                mem_wdata.in_use = 1'b0;
                seg_cnt_next     = seg_cnt_reg + 1'b1;
            end
            ffsa_pkg::S_AWR_HIT: begin
                mem_we           = 1'b1;
                mem_waddr        = hit_idx_reg[AW-1:0];
                mem_wdata.start  = hit_reg.start;
                mem_wdata.total  = split_reg ? head16 : hit_reg.total;
                mem_wdata.in_use = 1'b1;
                res_next.status        = ffsa_pkg::ST_OK;
                res_next.data_offset   = hit_reg.start + ffsa_pkg::HDR16;
                res_next.granted_bytes = split_reg ? alloc_reg[15:0] :
                                         ffsa_pkg::capacity(hit_reg.total);
            end
            ffsa_pkg::S_FEVAL: begin
                // The entry after the hit is in the read register now.
                mstart_next = prev_free ? prev_reg.start : hit_reg.start;
                mtotal_next = prev_free ? (prev_reg.total + sum_hn) : sum_hn;
                widx_next   = hit_idx_reg - CW'(prev_free);
                rm_cnt_next = 2'(next_free) + 2'(prev_free);
                k_next      = hit_idx_reg + 1'b1 + CW'(next_free);
            end
            ffsa_pkg::S_FWR: begin
                mem_we           = 1'b1;
                mem_waddr        = widx_reg[AW-1:0];
                mem_wdata.start  = mstart_reg;
                mem_wdata.total  = mtotal_reg;
                mem_wdata.in_use = 1'b0;
                res_next.status        = ffsa_pkg::ST_OK;
                res_next.data_offset   = mstart_reg + ffsa_pkg::HDR16;
                res_next.granted_bytes = ffsa_pkg::capacity(mtotal_reg);
            end
            ffsa_pkg::S_FSHIFT: begin
                // Close the gap left by merged entries, lowest first.
                if (pw_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pw_addr_reg;
                    mem_wdata = rd_entry;
                end
                if (fshift_more) begin
                    mem_raddr    = k_reg[AW-1:0];
                    pw_vld_next  = 1'b1;
                    pw_addr_next = AW'(k_reg - CW'(rm_cnt_reg));
                    k_next       = k_reg + 1'b1;
                end else begin
                    seg_cnt_next = seg_cnt_reg - CW'(rm_cnt_reg);
                end
            end
            ffsa_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ffsa_pkg::S_IDLE;
            buf_bytes_reg <= ffsa_pkg::BUFFER_BYTES_RST;
            fresh_reg     <= 1'b1;
            seg_cnt_reg   <= CW'(1);
            chk_vld_reg   <= 1'b0;
            pw_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            rd_fresh_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            pw_vld_reg   <= pw_vld_next;
            m_valid_reg  <= m_valid_next;
            rd_fresh_reg <= fresh_reg && (mem_raddr == '0);
            if (cfg_wr_en) begin
                buf_bytes_reg <= cfg_wr_data;
                fresh_reg     <= 1'b1;
                seg_cnt_reg   <= CW'(1);
            end else begin
                seg_cnt_reg <= seg_cnt_next;
                if (mem_we && mem_waddr == '0) begin
                    fresh_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        req_reg     <= req_next;
        rel_reg     <= rel_next;
        alloc_reg   <= alloc_next;
        need_reg    <= need_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        prev_reg    <= prev_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        split_reg   <= split_next;
        k_reg       <= k_next;
        pw_addr_reg <= pw_addr_next;
        mstart_reg  <= mstart_next;
        mtotal_reg  <= mtotal_next;
        widx_reg    <= widx_next;
        rm_cnt_reg  <= rm_cnt_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A request beat is followed by a busy state in which the input is not ready.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a request beat");

    // The table always holds between one and MAX_SEGMENTS segments.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_cnt_reg != '0) && (seg_cnt_reg <= MAX_CNT))
        else $error("segment count out of range");

    // A failed request reports no region.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ffsa_pkg::ST_OK)) |->
        ((m_data.data_offset == 16'd0) && (m_data.granted_bytes == 16'd0)))
        else $error("failed result carries a nonzero region");

    // A buffer size write leaves a single segment.
    a_cfg_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (seg_cnt_reg == CW'(1)))
        else $error("buffer size write did not reinitialize the table");

endmodule

`default_nettype wire
